### hdl/mos_pkg.sv
// Package for the median block: item types and the cell command codes.
package mos_pkg;

  // One input item.
  typedef struct packed {
    logic               has_value;
    logic signed [31:0] sample;
    logic               is_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [32:0] median_doubled;
    logic [6:0]         item_count;
    logic               set_empty;
    logic               overflowed;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  // Width of a stored value.
  localparam int VALUE_W = 32;

endpackage

### hdl/median_of_set.sv
// Top level of the median block: insertion chain and result sequencer.
//
// Input channel (in_valid, in_stall, in_item): one value per item. An item
// with has_value set adds its sample to the set; an item with is_last set
// closes the set, after adding its own sample if it carries one.
// Result channel (out_valid, out_stall, out_item): one item per closed set,
// holding twice the median, the value count, an empty flag and an overflow
// flag. Values beyond MAX_ITEMS are dropped and flagged.
// Throughput: one item per cycle while a set is loading, since every cell
// compares with the new value and takes its neighbor's value in the same
// cycle. After a closing item with n values the chain shifts toward its
// head (n-1)/2 times (none for an empty set), one place a cycle, then the
// result is registered; the input stalls until the result has been
// registered. The next set starts in the cycle after.
// A stalled result waits in the output register; loading of the next set
// goes on meanwhile, and only its closing waits for the register to free.
// Reset empties the chain and the output register; no clearing pass.
module median_of_set #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mos_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mos_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  mos_pkg::state_t   state_r;
  mos_pkg::state_t   state_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     count_add;
  logic [CW-1:0]     shift_r;
  logic [CW-1:0]     shift_nxt;
  logic              ovf_r;
  logic              ovf_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  mos_pkg::out_item_t out_r;
  mos_pkg::out_item_t out_nxt;
  mos_pkg::cell_op_t op;
  logic              in_acc;
  logic              room;
  logic [CW+6:0]     count_ext;
  logic signed [32:0] head0;
  logic signed [32:0] head1;

  // Chain wiring; the extra top position is an empty neighbor.
  logic                               cell_valid [0:MAX_ITEMS];
  logic signed [mos_pkg::VALUE_W-1:0] cell_val   [0:MAX_ITEMS];
  logic                               cell_gt    [0:MAX_ITEMS-1];

  assign cell_valid[MAX_ITEMS] = 1'b0;
  assign cell_val[MAX_ITEMS]   = '0;

  // Row of cells.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_head
      mos_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .ins_val    (in_item.sample),
        .prev_valid (1'b1),
        .prev_gt    (1'b0),
        .prev_val   (in_item.sample),
        .next_valid (cell_valid[i+1]),
        .next_val   (cell_val[i+1]),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i]),
        .val        (cell_val[i])
      );
    end else begin : g_body
      mos_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .ins_val    (in_item.sample),
        .prev_valid (cell_valid[i-1]),
        .prev_gt    (cell_gt[i-1]),
        .prev_val   (cell_val[i-1]),
        .next_valid (cell_valid[i+1]),
        .next_val   (cell_val[i+1]),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i]),
        .val        (cell_val[i])
      );
    end
  end

  assign in_stall  = (state_r != mos_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (count_r < CW'(MAX_ITEMS));
  assign count_add = count_r + CW'(1);
  assign count_ext = {7'b0, count_r};
  assign head0     = 33'(cell_val[0]);
  assign head1     = 33'(cell_val[1]);

  // Sequencer: load, shift the middle to the head, then emit.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    shift_nxt     = shift_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    op            = mos_pkg::CELL_HOLD;
    case (state_r)
      mos_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item.has_value) begin
            if (room) begin
              op        = mos_pkg::CELL_INSERT;
              count_nxt = count_add;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_item.is_last) begin
            // Head must hold sorted position (n-1)/2.
            if (count_nxt == '0) begin
              shift_nxt = '0;
            end else begin
              shift_nxt = (count_nxt - CW'(1)) >> 1;
            end
            state_nxt = (shift_nxt == '0) ? mos_pkg::ST_EMIT : mos_pkg::ST_SHIFT;
          end
        end
      end
      mos_pkg::ST_SHIFT: begin
        op        = mos_pkg::CELL_SHIFT;
        shift_nxt = shift_r - CW'(1);
        if (shift_r == CW'(1)) begin
          state_nxt = mos_pkg::ST_EMIT;
        end
      end
      mos_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          if (count_r == '0) begin
            out_nxt.median_doubled = '0;
          end else if (count_r[0]) begin
            out_nxt.median_doubled = head0 + head0;
          end else begin
            out_nxt.median_doubled = head0 + head1;
          end
          out_nxt.item_count = count_ext[6:0];
          out_nxt.set_empty  = (count_r == '0);
          out_nxt.overflowed = ovf_r;
          out_valid_nxt      = 1'b1;
          op                 = mos_pkg::CELL_CLEAR;
          count_nxt          = '0;
          ovf_nxt            = 1'b0;
          state_nxt          = mos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mos_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mos_pkg::ST_IDLE;
      count_r     <= '0;
      shift_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      shift_r     <= shift_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hdl/mos_cell.sv
// One cell of the sorted chain: holds one value and its valid bit.
module mos_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mos_pkg::cell_op_t                  op,
  input  logic signed [mos_pkg::VALUE_W-1:0] ins_val,
  input  logic                               prev_valid,
  input  logic                               prev_gt,
  input  logic signed [mos_pkg::VALUE_W-1:0] prev_val,
  input  logic                               next_valid,
  input  logic signed [mos_pkg::VALUE_W-1:0] next_val,
  output logic                               valid,
  output logic                               gt,
  output logic signed [mos_pkg::VALUE_W-1:0] val
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic signed [mos_pkg::VALUE_W-1:0] val_r;
  logic signed [mos_pkg::VALUE_W-1:0] val_nxt;

  // A held value greater than the new one must move up by one place.
  assign gt = valid_r && (val_r > ins_val);

  // Next contents for each command.
  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    case (op)
      mos_pkg::CELL_INSERT: begin
        // Take the neighbor's value if it also moves, else the new value.
        if (gt || (!valid_r && prev_valid)) begin
          val_nxt   = prev_gt ? prev_val : ins_val;
          valid_nxt = 1'b1;
        end
      end
      mos_pkg::CELL_SHIFT: begin
        val_nxt   = next_val;
        valid_nxt = next_valid;
      end
      mos_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // Valid bit is control state and resets; the value does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign valid = valid_r;
  assign val   = val_r;

endmodule
